>>> sv/scsa_pkg.sv
// shared types, constants and parameter defaults for the size class slab allocator
package scsa_pkg;

   localparam int NUM_CLASSES_DEF     = 64;
   localparam int MAX_CLASS_BYTES_DEF = 512;
   localparam int BLOCK_BYTES_DEF     = 4096;
   localparam int HEAP_BYTES_DEF      = 65536;

   localparam int SLOT_UNIT  = 8;
   localparam int SLOT_SH    = 3;
   localparam int DATA_W     = 16;
   localparam int ADDR_W     = 17;
   localparam int UNIT_W     = ADDR_W - SLOT_SH;
   localparam int LINK_AW    = DATA_W - SLOT_SH;
   localparam int LINK_DEPTH = 1 << LINK_AW;

   localparam int REQ_DATA_W = 2 * DATA_W;
   localparam int RSP_DATA_W = DATA_W;
   localparam int ST_W       = 2;

   localparam logic KIND_ALLOC = 1'b0;
   localparam logic KIND_FREE  = 1'b1;

   typedef enum logic [ST_W-1:0] {
      ST_OK       = 2'd0,
      ST_NULL     = 2'd1,
      ST_OVERSIZE = 2'd2,
      ST_OOM      = 2'd3
   } st_type;

   // per class state word
   typedef struct packed {
      logic [DATA_W-1:0] head;
      logic [ADDR_W-1:0] ptr;
      logic [ADDR_W-1:0] lim;
   } cls_word_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_sts_type;

endpackage

>>> sv/scsa_ram.sv
// generic single write port, single read port ram with registered read data
module scsa_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

>>> sv/scsa_div.sv
// iterative restoring remainder unit, one quotient bit per cycle
module scsa_div #(
   parameter int DVD_W = 14,
   parameter int DVS_W = 7
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [DVD_W-1:0]          dividend,
   input  logic [DVS_W-1:0]          divisor,
   output logic [DVS_W-1:0]          rem,
   output scsa_pkg::div_sts_type     sts
);
   import scsa_pkg::*;

   localparam int CNT_W = $clog2(DVD_W + 1);

   logic [DVD_W-1:0] dvd_ff;
   logic [DVS_W-1:0] dvs_ff;
   logic [DVS_W-1:0] rem_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff;
   logic             done_ff;

   logic [DVS_W:0]   trial;
   logic [DVS_W:0]   diff;
   logic             fits;
   logic [DVS_W-1:0] rem_in;

   always_comb begin
      trial  = {rem_ff, dvd_ff[DVD_W-1]};
      fits   = trial >= {1'b0, dvs_ff};
      diff   = trial - {1'b0, dvs_ff};
      rem_in = fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(DVD_W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         dvd_ff <= dividend;
         dvs_ff <= divisor;
         rem_ff <= '0;
      end else if (busy_ff) begin
         dvd_ff <= dvd_ff << 1;
         rem_ff <= rem_in;
      end
   end

   assign rem      = rem_ff;
   assign sts.busy = busy_ff;
   assign sts.done = done_ff;

endmodule

>>> sv/size_class_slab_allocator.sv
// Size class slab allocator: allocate and free requests over per class free lists.
// req channel: one item per request; tuser is the kind (0 allocate, 1 free),
// tdata holds request_size in bits 15:0 and free_address in bits 31:16.
// rsp channel: one item per request; tdata is slot_address, tuser is status
// (0 ok, 1 null request, 2 oversize, 3 out of memory).
// Requests are handled one at a time; req_tready is high only while idle.
// Null and oversize requests go from idle straight to the output state; frees
// and bump allocations pass the lookup state first, and free list pops add a link read state.
// A request that must carve a new heap block runs the slot alignment through the
// shared remainder unit, one bit per cycle over 14 bits, and then fits the block.
// The result sits in an output register; a new request is taken while it waits,
// but that request cannot finish until the old result is taken by rsp_tready.
// Reset empties every free list and current block at once through one valid
// bit per class and sets the heap back to its start; there is no clearing pass.
// The link store is not cleared, and no request ever reads an entry of it that
// was not written by an earlier free.
module size_class_slab_allocator #(
   parameter int NUM_CLASSES     = scsa_pkg::NUM_CLASSES_DEF,
   parameter int MAX_CLASS_BYTES = scsa_pkg::MAX_CLASS_BYTES_DEF,
   parameter int BLOCK_BYTES     = scsa_pkg::BLOCK_BYTES_DEF,
   parameter int HEAP_BYTES      = scsa_pkg::HEAP_BYTES_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [scsa_pkg::REQ_DATA_W-1:0]  req_tdata,   // request_size, free_address
   input  logic                             req_tuser,   // kind
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [scsa_pkg::RSP_DATA_W-1:0]  rsp_tdata,   // slot_address
   output logic [scsa_pkg::ST_W-1:0]        rsp_tuser    // status
);
   import scsa_pkg::*;

   localparam int CLS_W  = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
   localparam int DIV_W  = $clog2(NUM_CLASSES + 1);
   localparam int SLOT_W = DIV_W + SLOT_SH;
   localparam int WORD_W = $bits(cls_word_type);

   localparam logic [ADDR_W:0]   BLOCK_X = (ADDR_W + 1)'(BLOCK_BYTES);
   localparam logic [ADDR_W:0]   HEAP_X  = (ADDR_W + 1)'(HEAP_BYTES);

   typedef enum logic [6:0] {
      S_IDLE = 7'b0000001,
      S_LOOK = 7'b0000010,
      S_LINK = 7'b0000100,
      S_DIV  = 7'b0001000,
      S_FIT  = 7'b0010000,
      S_OUT  = 7'b0100000,
      S_SPARE = 7'b1000000
   } fsm_type;

   fsm_type            state_ff, state_in;
   logic               kind_ff;
   logic [DATA_W-1:0]  faddr_ff;
   logic [CLS_W-1:0]   cls_ff;
   logic               cval_ff;
   logic [NUM_CLASSES-1:0] valid_ff;
   cls_word_type       word_ff, word_in;
   logic [ADDR_W-1:0]  heap_ff, heap_in;
   logic [UNIT_W-1:0]  body_ff, body_in;
   logic [ADDR_W-1:0]  ptrn_ff, ptrn_in;
   logic [ADDR_W-1:0]  limn_ff, limn_in;
   logic [DATA_W-1:0]  res_addr_ff, res_addr_in;
   st_type             res_st_ff, res_st_in;
   logic               rsp_valid_ff;
   logic [DATA_W-1:0]  rsp_data_ff;
   st_type             rsp_st_ff;

   logic [DATA_W-1:0]  req_size;
   logic [DATA_W-1:0]  req_addr;
   logic [ADDR_W-1:0]  size_sum;
   logic [UNIT_W-1:0]  ceil_units;
   logic [UNIT_W-1:0]  cls_full;
   logic [CLS_W-1:0]   cls_req;
   logic               oversize;
   logic               req_null;
   logic               req_acc;

   logic [WORD_W-1:0]  cram_rdata;
   logic               cram_we;
   cls_word_type       cram_wdata;
   cls_word_type       look_word;
   logic               link_we;
   logic [DATA_W-1:0]  link_rdata;

   logic [DIV_W-1:0]   dvs;
   logic [SLOT_W-1:0]  slot;
   logic [ADDR_W-1:0]  slot_a;
   logic               heap_full;
   logic               div_start;
   logic [DIV_W-1:0]   div_rem;
   div_sts_type        div_sts;
   logic [UNIT_W-1:0]  pad;
   logic [UNIT_W-1:0]  aligned;

   // request decode
   always_comb begin
      req_size   = req_tdata[DATA_W-1:0];
      req_addr   = req_tdata[REQ_DATA_W-1:DATA_W];
      size_sum   = {1'b0, req_size} + ADDR_W'(SLOT_UNIT - 1);
      ceil_units = size_sum[ADDR_W-1:SLOT_SH];
      cls_full   = (ceil_units == '0) ? '0 : ceil_units - UNIT_W'(1);
      cls_req    = cls_full[CLS_W-1:0];
      oversize   = (req_size > DATA_W'(MAX_CLASS_BYTES)) ||
                   (ceil_units > UNIT_W'(NUM_CLASSES));
      req_null   = (req_tuser == KIND_ALLOC) ? (req_size == '0) : (req_addr == '0);
      req_acc    = req_tvalid && req_tready;
   end

   assign req_tready = (state_ff == S_IDLE);

   // class geometry
   always_comb begin
      dvs       = DIV_W'(cls_ff) + DIV_W'(1);
      slot      = {dvs, 3'b000};
      slot_a    = ADDR_W'(slot);
      heap_full = ({1'b0, heap_ff} + BLOCK_X) > HEAP_X;
      look_word = cval_ff ? cls_word_type'(cram_rdata) : '0;
      pad       = (div_rem == '0) ? '0 : UNIT_W'(dvs - div_rem);
      aligned   = body_ff + pad;
   end

   scsa_ram #(.WIDTH(WORD_W), .DEPTH(NUM_CLASSES)) u_cls_ram (
      .clock (clock),
      .we    (cram_we),
      .waddr (cls_ff),
      .wdata (cram_wdata),
      .raddr (cls_req),
      .rdata (cram_rdata)
   );

   scsa_ram #(.WIDTH(DATA_W), .DEPTH(LINK_DEPTH)) u_link_ram (
      .clock (clock),
      .we    (link_we),
      .waddr (faddr_ff[DATA_W-1:SLOT_SH]),
      .wdata (look_word.head),
      .raddr (look_word.head[DATA_W-1:SLOT_SH]),
      .rdata (link_rdata)
   );

   scsa_div #(.DVD_W(UNIT_W), .DVS_W(DIV_W)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (body_in),
      .divisor  (dvs),
      .rem      (div_rem),
      .sts      (div_sts)
   );

   // sequencer
   always_comb begin
      state_in    = state_ff;
      word_in     = word_ff;
      heap_in     = heap_ff;
      body_in     = body_ff;
      ptrn_in     = ptrn_ff;
      limn_in     = limn_ff;
      res_addr_in = res_addr_ff;
      res_st_in   = res_st_ff;
      cram_we     = 1'b0;
      cram_wdata  = word_ff;
      link_we     = 1'b0;
      div_start   = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               res_addr_in = '0;
               if (req_null) begin
                  res_st_in = ST_NULL;
                  state_in  = S_OUT;
               end else if (oversize) begin
                  res_st_in = ST_OVERSIZE;
                  state_in  = S_OUT;
               end else begin
                  res_st_in = ST_OK;
                  state_in  = S_LOOK;
               end
            end
         end
         S_LOOK: begin
            word_in = look_word;
            if (kind_ff == KIND_FREE) begin
               // push: old head goes to the link store
               cram_we         = 1'b1;
               cram_wdata      = look_word;
               cram_wdata.head = faddr_ff;
               link_we         = 1'b1;
               state_in        = S_OUT;
            end else if (look_word.head != '0) begin
               res_addr_in = look_word.head;
               state_in    = S_LINK;
            end else if (look_word.ptr != '0 && look_word.ptr < look_word.lim) begin
               res_addr_in    = look_word.ptr[DATA_W-1:0];
               cram_we        = 1'b1;
               cram_wdata     = look_word;
               cram_wdata.ptr = look_word.ptr + slot_a;
               state_in       = S_OUT;
            end else if (heap_full) begin
               res_st_in = ST_OOM;
               state_in  = S_OUT;
            end else begin
               // first slot past the header word, rounded up to the slot size
               body_in   = heap_ff[ADDR_W-1:SLOT_SH] + UNIT_W'(1);
               div_start = 1'b1;
               state_in  = S_DIV;
            end
         end
         S_LINK: begin
            cram_we         = 1'b1;
            cram_wdata      = word_ff;
            cram_wdata.head = link_rdata;
            state_in        = S_OUT;
         end
         S_DIV: begin
            if (div_sts.done) begin
               ptrn_in  = {aligned, 3'b000};
               limn_in  = heap_ff + ADDR_W'(BLOCK_BYTES) - slot_a + ADDR_W'(1);
               heap_in  = heap_ff + ADDR_W'(BLOCK_BYTES);
               state_in = S_FIT;
            end
         end
         S_FIT: begin
            cram_we        = 1'b1;
            cram_wdata     = word_ff;
            cram_wdata.lim = limn_ff;
            if (ptrn_ff >= limn_ff) begin
               // block consumed but too small for one slot
               cram_wdata.ptr = ptrn_ff;
               res_st_in      = ST_OOM;
            end else begin
               cram_wdata.ptr = ptrn_ff + slot_a;
               res_addr_in    = ptrn_ff[DATA_W-1:0];
            end
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         valid_ff     <= '0;
         heap_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         heap_ff  <= heap_in;
         if (cram_we) begin
            valid_ff[cls_ff] <= 1'b1;
         end
         if (state_ff == S_OUT && (!rsp_valid_ff || rsp_tready)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         kind_ff  <= req_tuser;
         faddr_ff <= req_addr;
         cls_ff   <= cls_req;
         cval_ff  <= valid_ff[cls_req];
      end
      word_ff     <= word_in;
      body_ff     <= body_in;
      ptrn_ff     <= ptrn_in;
      limn_ff     <= limn_in;
      res_addr_ff <= res_addr_in;
      res_st_ff   <= res_st_in;
      if (state_ff == S_OUT && (!rsp_valid_ff || rsp_tready)) begin
         rsp_data_ff <= res_addr_ff;
         rsp_st_ff   <= res_st_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_st_ff;

`ifndef SYNTHESIS
   a_addr_zero_on_fail: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != ST_OK) |-> (rsp_tdata == '0))
      else $error("failed request carries a slot address");

   a_div_only_in_div: assert property (@(posedge clock) disable iff (reset)
      div_sts.busy |-> (state_ff == S_DIV))
      else $error("remainder unit busy outside refill");

   a_accept_next: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> (state_ff == S_LOOK || state_ff == S_OUT))
      else $error("accepted item not dispatched");

   a_heap_bound: assert property (@(posedge clock) disable iff (reset)
      heap_ff <= ADDR_W'(HEAP_BYTES))
      else $error("heap top beyond heap size");
`endif

endmodule
